/* rtl/core/mlp_pkg.sv */
// Shared types, codes and arithmetic helpers of the two-layer perceptron unit.
// Holds the sigmoid lookup table, built at elaboration time.
// No dependencies.
package mlp_pkg;

    localparam int MAX_INPUTS  = 8;
    localparam int MAX_HIDDEN  = 32;
    localparam int MAX_OUTPUTS = 8;
    localparam int FRAC_BITS   = 12;
    localparam int ACC_W       = 40;

    localparam logic [2:0] OP_W1   = 3'd0;
    localparam logic [2:0] OP_B1   = 3'd1;
    localparam logic [2:0] OP_W2   = 3'd2;
    localparam logic [2:0] OP_B2   = 3'd3;
    localparam logic [2:0] OP_FEED = 3'd4;

    localparam logic [1:0] ACT_RELU = 2'd1;
    localparam logic [1:0] ACT_SIG  = 2'd2;

    localparam logic [2:0] REG_NI   = 3'd0;
    localparam logic [2:0] REG_NH   = 3'd1;
    localparam logic [2:0] REG_NO   = 3'd2;
    localparam logic [2:0] REG_HACT = 3'd3;
    localparam logic [2:0] REG_OACT = 3'd4;

    // One load beat, broadcast to every store.
    typedef struct packed {
        logic              we;
        logic [2:0]        op;
        logic [4:0]        row;
        logic [4:0]        col;
        logic signed [15:0] data;
    } load_t;

    // One hidden value travelling down the cell chain.
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic [4:0]        h;
        logic signed [15:0] value;
    } tok_t;

    typedef logic [255:0][15:0] sig_tab_t;

    // Builds the sigmoid table from rounded powers of e^-1/16.
    function automatic sig_tab_t build_sig_tab();
        logic [63:0] ek [129];
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] q;
        logic [63:0] s;
        int          kk;
        sig_tab_t    tab;
        e = 64'd1 << 32;
        ek[0] = e;
        for (int k = 1; k <= 128; k++) begin
            e = (e * 64'd4034748382 + (64'd1 << 31)) >> 32;
            ek[k] = e;
        end
        for (int i = 0; i < 256; i++) begin
            kk  = (i >= 128) ? (i - 128) : (128 - i);
            den = (64'd1 << 32) + ek[kk];
            num = (64'd1 << 48) + (den >> 1);
            rem = '0;
            q   = '0;
            // Restoring long division, one quotient bit per step.
            for (int b = 63; b >= 0; b--) begin
                rem = {rem[62:0], num[b]};
                if (rem >= den) begin
                    rem  = rem - den;
                    q[b] = 1'b1;
                end
            end
            s = (i >= 128) ? q : (64'd65536 - q);
            s = (s + 64'd8) >> 4;
            tab[i] = s[15:0];
        end
        return tab;
    endfunction

    localparam sig_tab_t SIG_TAB = build_sig_tab();

    // Adds the bias, rounds half up to the Q4.12 grid and saturates.
    function automatic logic signed [15:0] sat_finish(input logic signed [ACC_W-1:0] acc,
                                                      input logic signed [15:0] bias);
        logic signed [ACC_W-1:0] s;
        logic signed [27:0]      r;
        s = acc + (ACC_W'(bias) <<< FRAC_BITS) + ACC_W'(2048);
        r = 28'(s >>> FRAC_BITS);
        if (r > 28'sd32767) begin
            return 16'sh7fff;
        end else if (r < -28'sd32768) begin
            return 16'sh8000;
        end
        return 16'(r);
    endfunction

    // Applies the selected activation; unknown codes pass the value through.
    function automatic logic signed [15:0] activate(input logic signed [15:0] v,
                                                    input logic [1:0] mode);
        case (mode)
            ACT_RELU: return v[15] ? 16'sd0 : v;
            ACT_SIG:  return $signed(SIG_TAB[{~v[15], v[14:8]}]);
            default:  return v;
        endcase
    endfunction

endpackage

/* rtl/core/mlp_hid_mac.sv */
// Hidden layer engine: input vector, input-to-hidden weights, hidden biases
// and one multiply-accumulate unit. Depends on mlp_pkg.
module mlp_hid_mac (
    input  logic                aclk,
    input  logic                aresetn,
    input  mlp_pkg::load_t      ld,
    input  logic                start,
    input  logic [2:0]          j_last,
    input  logic [4:0]          h_last,
    input  logic [1:0]          act_mode,
    output mlp_pkg::tok_t       tok_o
);

    logic signed [15:0] x_reg [mlp_pkg::MAX_INPUTS];
    logic signed [15:0] w1_mem [mlp_pkg::MAX_INPUTS * mlp_pkg::MAX_HIDDEN];
    logic signed [15:0] b1_mem [mlp_pkg::MAX_HIDDEN];

    logic       run_reg;
    logic [2:0] j_reg;
    logic [4:0] h_reg;

    logic               v1_reg, f1_reg, lj1_reg, fh1_reg, lh1_reg;
    logic [4:0]         h1_reg;
    logic signed [15:0] w1_rd_reg, x_rd_reg, b1_rd_reg;

    logic               v2_reg, f2_reg, lj2_reg, fh2_reg, lh2_reg;
    logic [4:0]         h2_reg;
    logic signed [31:0] prod_reg;
    logic signed [15:0] b2_reg;

    logic signed [mlp_pkg::ACC_W-1:0] acc_reg;
    logic               v3_reg, fh3_reg, lh3_reg;
    logic [4:0]         h3_reg;
    logic signed [15:0] b3_reg;

    logic               v4_reg, fh4_reg, lh4_reg;
    logic [4:0]         h4_reg;
    logic signed [15:0] sat_reg;

    mlp_pkg::tok_t      tok_reg;

    // Store writes from load beats.
    always_ff @(posedge aclk) begin
        if (ld.we && ld.op == mlp_pkg::OP_FEED && ld.row < 5'(mlp_pkg::MAX_INPUTS)) begin
            x_reg[ld.row[2:0]] <= ld.data;
        end
        if (ld.we && ld.op == mlp_pkg::OP_W1 && ld.row < 5'(mlp_pkg::MAX_INPUTS)) begin
            w1_mem[{ld.row[2:0], ld.col}] <= ld.data;
        end
        if (ld.we && ld.op == mlp_pkg::OP_B1) begin
            b1_mem[ld.row] <= ld.data;
        end
    end

    // Index sequencer: inputs inner, hidden neurons outer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            j_reg   <= '0;
            h_reg   <= '0;
        end else if (start) begin
            run_reg <= 1'b1;
            j_reg   <= '0;
            h_reg   <= '0;
        end else if (run_reg) begin
            if (j_reg == j_last) begin
                j_reg <= '0;
                if (h_reg == h_last) begin
                    run_reg <= 1'b0;
                end else begin
                    h_reg <= h_reg + 5'd1;
                end
            end else begin
                j_reg <= j_reg + 3'd1;
            end
        end
    end

    // Stage one: registered store reads.
    always_ff @(posedge aclk) begin
        w1_rd_reg <= w1_mem[{j_reg, h_reg}];
        x_rd_reg  <= x_reg[j_reg];
        b1_rd_reg <= b1_mem[h_reg];
        f1_reg    <= (j_reg == 3'd0);
        lj1_reg   <= (j_reg == j_last);
        fh1_reg   <= (h_reg == 5'd0);
        lh1_reg   <= (h_reg == h_last);
        h1_reg    <= h_reg;
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= run_reg;
        end
    end

    // Stage two: product.
    always_ff @(posedge aclk) begin
        prod_reg <= x_rd_reg * w1_rd_reg;
        b2_reg   <= b1_rd_reg;
        f2_reg   <= f1_reg;
        lj2_reg  <= lj1_reg;
        fh2_reg  <= fh1_reg;
        lh2_reg  <= lh1_reg;
        h2_reg   <= h1_reg;
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else begin
            v2_reg <= v1_reg;
        end
    end

    // Stage three: accumulate, flag the end of a neuron.
    always_ff @(posedge aclk) begin
        if (v2_reg) begin
            acc_reg <= f2_reg ? mlp_pkg::ACC_W'(prod_reg)
                              : acc_reg + mlp_pkg::ACC_W'(prod_reg);
        end
        b3_reg  <= b2_reg;
        fh3_reg <= fh2_reg;
        lh3_reg <= lh2_reg;
        h3_reg  <= h2_reg;
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else begin
            v3_reg <= v2_reg && lj2_reg;
        end
    end

    // Stage four: bias, rounding and saturation.
    always_ff @(posedge aclk) begin
        sat_reg <= mlp_pkg::sat_finish(acc_reg, b3_reg);
        fh4_reg <= fh3_reg;
        lh4_reg <= lh3_reg;
        h4_reg  <= h3_reg;
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else begin
            v4_reg <= v3_reg;
        end
    end

    // Stage five: activation, handed to the first cell.
    always_ff @(posedge aclk) begin
        tok_reg.value <= mlp_pkg::activate(sat_reg, act_mode);
        tok_reg.first <= fh4_reg;
        tok_reg.last  <= lh4_reg;
        tok_reg.h     <= h4_reg;
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg.valid <= v4_reg;
        end
    end

    assign tok_o = tok_reg;

endmodule

/* rtl/core/mlp_out_cell.sv */
// One output neuron cell: its weight column, its bias and an accumulator.
// Passes each hidden value on to its neighbor in the next cycle. Depends on mlp_pkg.
module mlp_out_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [4:0]          cell_idx,
    input  mlp_pkg::load_t      ld,
    input  logic [1:0]          act_mode,
    input  mlp_pkg::tok_t       tok_i,
    output mlp_pkg::tok_t       tok_o,
    output logic signed [15:0]  res,
    output logic                done
);

    logic signed [15:0] w2_mem [mlp_pkg::MAX_HIDDEN];
    logic signed [15:0] bias_reg;

    mlp_pkg::tok_t      tok_reg;
    logic signed [15:0] w_rd_reg;

    logic               v2_reg, f2_reg, l2_reg;
    logic signed [31:0] prod_reg;
    logic signed [mlp_pkg::ACC_W-1:0] acc_reg;
    logic               v3_reg, v4_reg;
    logic signed [15:0] sat_reg;
    logic signed [15:0] res_reg;
    logic               done_reg;

    // Weight column and bias writes addressed to this cell.
    always_ff @(posedge aclk) begin
        if (ld.we && ld.op == mlp_pkg::OP_W2 && ld.col == cell_idx) begin
            w2_mem[ld.row] <= ld.data;
        end
        if (ld.we && ld.op == mlp_pkg::OP_B2 && ld.row == cell_idx) begin
            bias_reg <= ld.data;
        end
    end

    // Stage one: take the beat and read the matching weight.
    always_ff @(posedge aclk) begin
        w_rd_reg <= w2_mem[tok_i.h];
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_i;
        end
    end

    // Stage two: product.
    always_ff @(posedge aclk) begin
        prod_reg <= tok_reg.value * w_rd_reg;
        f2_reg   <= tok_reg.first;
        l2_reg   <= tok_reg.last;
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else begin
            v2_reg <= tok_reg.valid;
        end
    end

    // Stage three: accumulate.
    always_ff @(posedge aclk) begin
        if (v2_reg) begin
            acc_reg <= f2_reg ? mlp_pkg::ACC_W'(prod_reg)
                              : acc_reg + mlp_pkg::ACC_W'(prod_reg);
        end
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else begin
            v3_reg <= v2_reg && l2_reg;
        end
    end

    // Stages four and five: finish the neuron and activate.
    always_ff @(posedge aclk) begin
        sat_reg <= mlp_pkg::sat_finish(acc_reg, bias_reg);
        if (v4_reg) begin
            res_reg <= mlp_pkg::activate(sat_reg, act_mode);
        end
        if (!aresetn) begin
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    assign tok_o = tok_reg;
    assign res   = res_reg;
    assign done  = done_reg;

endmodule

/* rtl/core/two_layer_mlp_inference_unit.sv */
// Two-layer perceptron inference unit: hidden MAC engine feeding a chain of
// output neuron cells. Depends on mlp_pkg, mlp_hid_mac and mlp_out_cell.
// After the feed beat for the last input row, the single hidden MAC works through
// all ni*nh products, its pipeline and the eight-cell chain finish the values,
// and m_tvalid rises; then one result beat per output neuron and per cycle while m_tready is high.
// Input is held off from that feed beat until the last result is taken, and
// load beats are accepted only while the unit is idle.
// Reset (aresetn, synchronous, active low) restores the registers to their
// defaults and clears control state; weight and bias stores are not cleared.
module two_layer_mlp_inference_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // opcode[2:0], row_index[7:3], col_index[12:8],
                                   // value[28:13], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_index[2:0], out_value[18:3], zero pad
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [5:0]  cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t state_reg;

    logic [3:0] ni_reg, no_reg;
    logic [5:0] nh_reg;
    logic [1:0] hact_reg, oact_reg;

    logic [3:0] ni_c, no_c;
    logic [5:0] nh_c;
    logic [2:0] j_last, k_last;
    logic [4:0] h_last;

    mlp_pkg::load_t ld;
    logic           s_beat, start;

    mlp_pkg::tok_t      chain [mlp_pkg::MAX_OUTPUTS + 1];
    logic signed [15:0] res   [mlp_pkg::MAX_OUTPUTS];
    logic               cell_done [mlp_pkg::MAX_OUTPUTS];

    logic [2:0]         k_reg;
    logic               m_valid_reg, m_last_reg;
    logic signed [15:0] m_value_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ni_reg   <= 4'd6;
            nh_reg   <= 6'd16;
            no_reg   <= 4'd1;
            hact_reg <= 2'd0;
            oact_reg <= 2'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                mlp_pkg::REG_NI:   ni_reg   <= cfg_data[3:0];
                mlp_pkg::REG_NH:   nh_reg   <= cfg_data;
                mlp_pkg::REG_NO:   no_reg   <= cfg_data[3:0];
                mlp_pkg::REG_HACT: hact_reg <= cfg_data[1:0];
                mlp_pkg::REG_OACT: oact_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Counts clamped to their legal ranges.
    always_comb begin
        ni_c = (ni_reg == 4'd0) ? 4'd1 : (ni_reg > 4'd8) ? 4'd8 : ni_reg;
        nh_c = (nh_reg == 6'd0) ? 6'd1 : (nh_reg > 6'd32) ? 6'd32 : nh_reg;
        no_c = (no_reg == 4'd0) ? 4'd1 : (no_reg > 4'd8) ? 4'd8 : no_reg;
        j_last = 3'(ni_c - 4'd1);
        h_last = 5'(nh_c - 6'd1);
        k_last = 3'(no_c - 4'd1);
    end

    // Input beat decode.
    assign s_tready = (state_reg == ST_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    always_comb begin
        ld.we   = s_beat;
        ld.op   = s_tdata[2:0];
        ld.row  = s_tdata[7:3];
        ld.col  = s_tdata[12:8];
        ld.data = $signed(s_tdata[28:13]);
    end
    assign start = s_beat && ld.op == mlp_pkg::OP_FEED && ld.row == {2'b00, j_last};

    mlp_hid_mac u_hid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ld       (ld),
        .start    (start),
        .j_last   (j_last),
        .h_last   (h_last),
        .act_mode (hact_reg),
        .tok_o    (chain[0])
    );

    // Row of output cells, each handing hidden values to the next.
    for (genvar g = 0; g < mlp_pkg::MAX_OUTPUTS; g++) begin : g_cell
        mlp_out_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (5'(g)),
            .ld       (ld),
            .act_mode (oact_reg),
            .tok_i    (chain[g]),
            .tok_o    (chain[g+1]),
            .res      (res[g]),
            .done     (cell_done[g])
        );
    end

    // Control and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
            k_reg       <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (cell_done[mlp_pkg::MAX_OUTPUTS-1]) begin
                        state_reg   <= ST_EMIT;
                        m_valid_reg <= 1'b1;
                        k_reg       <= '0;
                        m_value_reg <= res[0];
                        m_last_reg  <= (k_last == 3'd0);
                    end
                end
                ST_EMIT: begin
                    if (m_tready) begin
                        if (m_last_reg) begin
                            m_valid_reg <= 1'b0;
                            m_last_reg  <= 1'b0;
                            state_reg   <= ST_IDLE;
                        end else begin
                            k_reg       <= k_reg + 3'd1;
                            m_value_reg <= res[k_reg + 3'd1];
                            m_last_reg  <= (k_reg + 3'd1 == k_last);
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {5'd0, m_value_reg, k_reg};

`ifndef SYNTH
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input accepted while a result is pending");
    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_done[mlp_pkg::MAX_OUTPUTS-1] |-> state_reg == ST_WAIT)
        else $error("cell chain finished outside the wait state");
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
        else $error("unit did not return to idle after the last result");
    a_cells_even: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_done[0] |-> !cell_done[mlp_pkg::MAX_OUTPUTS-1])
        else $error("cell chain timing skew lost");
`endif

endmodule
